@@ hw/rtl/rgb_inverse_minmax_normalizer_macros.svh @@
// assertion macros for the rgb inverse min-max normalizer
// no dependencies; define NO_ASSERTIONS to compile the checks out
`ifndef RGB_INVERSE_MINMAX_NORMALIZER_MACROS_SVH
`define RGB_INVERSE_MINMAX_NORMALIZER_MACROS_SVH
`ifndef NO_ASSERTIONS
// property that must hold at every clock edge outside reset
`define RIMN_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition in one cycle that implies a consequence in the next
`define RIMN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define RIMN_ASSERT(label, clk, rst_n, prop, msg)
`define RIMN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ hw/rtl/rimn_pkg.sv @@
// shared types and constants for the rgb inverse min-max normalizer
// no dependencies
`timescale 1ns / 1ps

package rimn_pkg;

	localparam int NUM_CH      = 3;
	localparam int RAW_W       = 16;
	localparam int DUTY_W      = 8;
	// numerator is diff * 255, fits in raw width plus duty width
	localparam int REM_W       = RAW_W + DUTY_W;
	localparam int IN_TDATA_W  = NUM_CH * RAW_W;
	localparam int OUT_TDATA_W = NUM_CH * DUTY_W;

	localparam logic [RAW_W-1:0]  THRESH_RESET = RAW_W'(20);
	localparam logic [DUTY_W-1:0] DUTY_FULL    = '1;

	localparam int QUEUE_DEPTH_DEF = 4;

	// classified request handed from the front to the back
	typedef struct packed {
		logic                          flat;
		logic                          zero;
		logic [RAW_W-1:0]              spread;
		logic [NUM_CH-1:0][RAW_W-1:0]  diff;
	} item_t;

	// state of one divider stage, three lanes sharing one divisor
	typedef struct packed {
		logic                          flat;
		logic                          zero;
		logic [RAW_W-1:0]              spread;
		logic [NUM_CH-1:0][REM_W-1:0]  rem;
		logic [NUM_CH-1:0][DUTY_W-1:0] quo;
	} div_t;

endpackage

@@ hw/rtl/rimn_front.sv @@
// front end: min/max search, spread, flat and zero classification and distances from the max per request
// depends on rimn_pkg
`timescale 1ns / 1ps

module rimn_front (
	input  logic [rimn_pkg::RAW_W-1:0] red,
	input  logic [rimn_pkg::RAW_W-1:0] green,
	input  logic [rimn_pkg::RAW_W-1:0] blue,
	input  logic [rimn_pkg::RAW_W-1:0] threshold,
	output rimn_pkg::item_t            item
);
	import rimn_pkg::*;

	logic [RAW_W-1:0] lo;
	logic [RAW_W-1:0] hi;
	logic [RAW_W-1:0] lo_rg;
	logic [RAW_W-1:0] hi_rg;
	logic [RAW_W-1:0] spread;

	// three-way min and max
	always_comb begin
		lo_rg = (green < red) ? green : red;
		hi_rg = (green > red) ? green : red;
		lo    = (blue < lo_rg) ? blue : lo_rg;
		hi    = (blue > hi_rg) ? blue : hi_rg;
	end

	assign spread = hi - lo;

	// classification and per-channel distance from the maximum
	always_comb begin
		item.flat    = spread < threshold;
		item.zero    = spread == '0;
		item.spread  = spread;
		item.diff[0] = hi - red;
		item.diff[1] = hi - green;
		item.diff[2] = hi - blue;
	end

endmodule

@@ hw/rtl/rimn_queue.sv @@
// short fifo between the front and the back end
// depends on rimn_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "rgb_inverse_minmax_normalizer_macros.svh"

module rimn_queue #(
	parameter int DEPTH = rimn_pkg::QUEUE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  rimn_pkg::item_t in_item,
	output logic            out_valid,
	input  logic            out_ready,
	output rimn_pkg::item_t out_item
);
	import rimn_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	item_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign in_ready  = count_q != CNT_W'(DEPTH);
	assign out_valid = count_q != '0;
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_item  = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`RIMN_ASSERT(a_count_bound, clk, arst_n, count_q <= CNT_W'(DEPTH), "queue count above depth")
	`RIMN_ASSERT_NEXT(a_push_fills, clk, arst_n, push, count_q != '0, "queue empty after a push")

endmodule

@@ hw/rtl/rimn_back.sv @@
// back end: eight-stage restoring divider on three lanes plus output select
// depends on rimn_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "rgb_inverse_minmax_normalizer_macros.svh"

module rimn_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  rimn_pkg::item_t                  in_item,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [rimn_pkg::OUT_TDATA_W-1:0] out_duty,
	output logic                             out_flat
);
	import rimn_pkg::*;

	logic [DUTY_W:1]                 vld_q;
	div_t                            stage_d [DUTY_W];
	div_t                            stage_q [1:DUTY_W];
	div_t                            head;
	div_t                            last;
	logic                            advance;
	logic [NUM_CH-1:0][DUTY_W-1:0]   duty;

	// whole pipeline moves when the output slot is free or being taken
	assign advance  = !vld_q[DUTY_W] || out_ready;
	assign in_ready = advance;

	// numerator diff * 255 as (diff << 8) - diff
	always_comb begin
		head.flat   = in_item.flat;
		head.zero   = in_item.zero;
		head.spread = in_item.spread;
		head.quo    = '0;
		for (int j = 0; j < NUM_CH; j++) begin
			head.rem[j] = {in_item.diff[j], {DUTY_W{1'b0}}}
				- {{DUTY_W{1'b0}}, in_item.diff[j]};
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (advance) begin
			vld_q <= {vld_q[DUTY_W-1:1], in_valid};
		end
	end

	// one quotient bit per stage, msb first
	for (genvar k = 0; k < DUTY_W; k++) begin : g_stage
		localparam int SH = DUTY_W - 1 - k;
		logic [REM_W-1:0] trial;
		div_t             nxt;

		if (k == 0) begin : g_first
			assign stage_d[k] = head;
		end else begin : g_rest
			assign stage_d[k] = stage_q[k];
		end

		assign trial = {{(REM_W-RAW_W){1'b0}}, stage_d[k].spread} << SH;

		always_comb begin
			nxt = stage_d[k];
			for (int j = 0; j < NUM_CH; j++) begin
				if (stage_d[k].rem[j] >= trial) begin
					nxt.rem[j]     = stage_d[k].rem[j] - trial;
					nxt.quo[j][SH] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (advance) begin
				stage_q[k+1] <= nxt;
			end
		end
	end

	assign last = stage_q[DUTY_W];

	// flat forces white, zero spread forces black
	always_comb begin
		for (int j = 0; j < NUM_CH; j++) begin
			if (last.flat) begin
				duty[j] = DUTY_FULL;
			end else if (last.zero) begin
				duty[j] = '0;
			end else begin
				duty[j] = last.quo[j];
			end
		end
	end

	assign out_valid = vld_q[DUTY_W];
	assign out_duty  = duty;
	assign out_flat  = last.flat;

	`RIMN_ASSERT_NEXT(a_hold_stalled, clk, arst_n, vld_q[DUTY_W] && !out_ready, vld_q[DUTY_W], "stalled result dropped")
	`RIMN_ASSERT(a_rem_below_div, clk, arst_n, !vld_q[DUTY_W] || last.zero || ((last.rem[0] < REM_W'(last.spread)) && (last.rem[1] < REM_W'(last.spread)) && (last.rem[2] < REM_W'(last.spread))), "final remainder not below divisor")

endmodule

@@ hw/rtl/rgb_inverse_minmax_normalizer.sv @@
// Inverse min-max normalizer for 16-bit rgb readings. Each request gives one
// result: duties of 255 with flat set when max-min is below flat_threshold,
// otherwise floor((max-v)*255/(max-min)) per channel (0 for all when the
// spread is zero). One request is accepted per clock cycle while the input
// fifo has room; a result passes through that fifo and then the eight-stage
// restoring divider (one quotient bit per stage) before it reaches the
// output. The fifo lets the input keep taking requests while the output
// stalls, until its QUEUE_DEPTH entries are full. flat_threshold is written
// through cfg_we/cfg_wdata and resets to 20; the user must write it only
// while no request is in flight, the block does not enforce this.
// depends on rimn_pkg, rimn_front, rimn_queue, rimn_back
`timescale 1ns / 1ps

module rgb_inverse_minmax_normalizer #(
	parameter int QUEUE_DEPTH = rimn_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [rimn_pkg::RAW_W-1:0]       cfg_wdata,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// raw_red [15:0], raw_green [31:16], raw_blue [47:32]
	input  logic [rimn_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// duty_red [7:0], duty_green [15:8], duty_blue [23:16]
	output logic [rimn_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	// flat [0]
	output logic                             m_axis_tuser
);
	import rimn_pkg::*;

	logic [RAW_W-1:0] threshold_q;
	item_t            front_item;
	item_t            queue_item;
	logic             queue_valid;
	logic             back_ready;

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESH_RESET;
		end else if (cfg_we) begin
			threshold_q <= cfg_wdata;
		end
	end

	// classify the incoming request
	rimn_front u_front (
		.red       (s_axis_tdata[RAW_W-1:0]),
		.green     (s_axis_tdata[2*RAW_W-1:RAW_W]),
		.blue      (s_axis_tdata[3*RAW_W-1:2*RAW_W]),
		.threshold (threshold_q),
		.item      (front_item)
	);

	// decoupling fifo
	rimn_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_item   (front_item),
		.out_valid (queue_valid),
		.out_ready (back_ready),
		.out_item  (queue_item)
	);

	// divider pipeline and output
	rimn_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (queue_valid),
		.in_ready  (back_ready),
		.in_item   (queue_item),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_duty  (m_axis_tdata),
		.out_flat  (m_axis_tuser)
	);

endmodule

@@ verif/rimn_checker.sv @@
// checker for the rgb inverse min-max normalizer: watches the request, result and
// register write channels, predicts each result and compares it field by field
// depends on rimn_pkg
`timescale 1ns / 1ps

module rimn_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [rimn_pkg::RAW_W-1:0]       cfg_wdata,
	input  logic                             s_axis_tvalid,
	input  logic                             s_axis_tready,
	// raw_red [15:0], raw_green [31:16], raw_blue [47:32]
	input  logic [rimn_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	input  logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// duty_red [7:0], duty_green [15:8], duty_blue [23:16]
	input  logic [rimn_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	// flat [0]
	input  logic                             m_axis_tuser,
	output int                               errors,
	output int                               pending,
	output int                               results,
	output int                               flat_results
);
	import rimn_pkg::*;

	typedef struct packed {
		logic [DUTY_W-1:0] red;
		logic [DUTY_W-1:0] green;
		logic [DUTY_W-1:0] blue;
		logic              flat;
	} duty_set_t;

	duty_set_t        duty_q[$];
	logic [RAW_W-1:0] thresh;

	// one channel mapped inversely between the min and the max, hi above lo
	function automatic logic [DUTY_W-1:0] inverse_scale(input logic [RAW_W-1:0] v,
			input logic [RAW_W-1:0] lo, input logic [RAW_W-1:0] hi);
		logic [31:0] num;
		if (v <= lo)
			return DUTY_FULL;
		if (v >= hi)
			return '0;
		num = 32'(hi - v) * 32'd255;
		return DUTY_W'(num / 32'(hi - lo));
	endfunction

	// expected duties for one rgb reading under the given flat threshold
	function automatic duty_set_t normalize_rgb(input logic [RAW_W-1:0] r,
			input logic [RAW_W-1:0] g, input logic [RAW_W-1:0] b,
			input logic [RAW_W-1:0] flat_thresh);
		logic [RAW_W-1:0] lo;
		logic [RAW_W-1:0] hi;
		duty_set_t        d;
		lo = r;
		hi = r;
		if (g < lo) lo = g;
		if (b < lo) lo = b;
		if (g > hi) hi = g;
		if (b > hi) hi = b;
		if (RAW_W'(hi - lo) < flat_thresh) begin
			d.red   = DUTY_FULL;
			d.green = DUTY_FULL;
			d.blue  = DUTY_FULL;
			d.flat  = 1'b1;
		end else if (hi == lo) begin
			// zero spread only gets here with a zero threshold
			d = '0;
		end else begin
			d.red   = inverse_scale(r, lo, hi);
			d.green = inverse_scale(g, lo, hi);
			d.blue  = inverse_scale(b, lo, hi);
			d.flat  = 1'b0;
		end
		return d;
	endfunction

	// returns 1 on a mismatch and reports it
	function automatic int field_check(input string name, input int want, input int got);
		if (want == got)
			return 0;
		$display("%0t: mismatch on %s: expected %0d, got %0d", $time, name, want, got);
		return 1;
	endfunction

	// shadow register, expected results in request order, compare on each result
	always @(posedge clk or negedge arst_n) begin : scoreboard
		duty_set_t want;
		duty_set_t got;
		int        bad;
		if (!arst_n) begin
			thresh       <= THRESH_RESET;
			duty_q.delete();
			errors       <= 0;
			pending      <= 0;
			results      <= 0;
			flat_results <= 0;
		end else begin
			bad = 0;
			if (cfg_we)
				thresh <= cfg_wdata;
			if (s_axis_tvalid && s_axis_tready)
				duty_q.push_back(normalize_rgb(s_axis_tdata[RAW_W-1:0],
					s_axis_tdata[2*RAW_W-1:RAW_W], s_axis_tdata[3*RAW_W-1:2*RAW_W], thresh));
			if (m_axis_tvalid && m_axis_tready) begin
				got.red   = m_axis_tdata[DUTY_W-1:0];
				got.green = m_axis_tdata[2*DUTY_W-1:DUTY_W];
				got.blue  = m_axis_tdata[3*DUTY_W-1:2*DUTY_W];
				got.flat  = m_axis_tuser;
				if (duty_q.size() == 0) begin
					$display("%0t: unexpected result: expected none, got %h flat %b",
						$time, m_axis_tdata, m_axis_tuser);
					bad++;
				end else begin
					want = duty_q.pop_front();
					bad += field_check("duty_red", want.red, got.red);
					bad += field_check("duty_green", want.green, got.green);
					bad += field_check("duty_blue", want.blue, got.blue);
					bad += field_check("flat", want.flat, got.flat);
					results      <= results + 1;
					flat_results <= flat_results + int'(want.flat);
				end
			end
			errors  <= errors + bad;
			pending <= duty_q.size();
		end
	end

endmodule

@@ verif/tb_top.sv @@
// testbench top for the rgb inverse min-max normalizer: clock, reset, requests,
// register writes and output stalls; checking is done in rimn_checker
// depends on rimn_pkg, rimn_checker and the normalizer rtl
`timescale 1ns / 1ps

module tb_top;
	import rimn_pkg::*;

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   cfg_we        = 1'b0;
	logic [RAW_W-1:0]       cfg_wdata     = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tuser;

	// no idling on either side while calm is set
	logic                   calm          = 1'b0;
	logic [RAW_W-1:0]       cur_thresh    = THRESH_RESET;
	int                     sent          = 0;
	int                     errors;
	int                     pending;
	int                     results;
	int                     flat_results;

	rgb_inverse_minmax_normalizer u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	rimn_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.errors        (errors),
		.pending       (pending),
		.results       (results),
		.flat_results  (flat_results)
	);

	// 50 MHz clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// result side stalls at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= calm || ($urandom_range(99) >= 17);
		end
	end

	// one request, with a random gap in front of it
	task automatic send_pixel(input logic [RAW_W-1:0] r, input logic [RAW_W-1:0] g,
			input logic [RAW_W-1:0] b);
		while (!calm && $urandom_range(99) < 17) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {b, g, r};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sent++;
	endtask

	// hold requests until every result is back and the pipeline is empty
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_thresh(input logic [RAW_W-1:0] v);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		cur_thresh = v;
	endtask

	// random reading: uniform, or shaped around the threshold, equal channels, extremes or small spreads
	task automatic random_pixel(output logic [RAW_W-1:0] r, output logic [RAW_W-1:0] g,
			output logic [RAW_W-1:0] b);
		logic [RAW_W-1:0] v [3];
		logic [RAW_W-1:0] t;
		int               spread;
		int               lo;
		int               j;
		case ($urandom_range(9))
			0, 1, 2, 3: begin
				foreach (v[k])
					v[k] = RAW_W'($urandom_range(65535));
			end
			4, 5: begin
				// spread within two of the threshold
				spread = int'(cur_thresh) + int'($urandom_range(4)) - 2;
				if (spread < 0) spread = 0;
				if (spread > 65535) spread = 65535;
				lo   = int'($urandom_range(65535 - spread));
				v[0] = RAW_W'(lo);
				v[1] = RAW_W'(lo + spread);
				v[2] = RAW_W'(lo + int'($urandom_range(spread)));
			end
			6: begin
				// two or three channels equal
				v[0] = RAW_W'($urandom_range(65535));
				v[1] = v[0];
				v[2] = $urandom_range(1) ? v[0] : RAW_W'($urandom_range(65535));
			end
			7: begin
				foreach (v[k])
					case ($urandom_range(2))
						0:       v[k] = '0;
						1:       v[k] = '1;
						default: v[k] = RAW_W'($urandom_range(65535));
					endcase
			end
			default: begin
				spread = int'($urandom_range(1, 300));
				lo     = int'($urandom_range(65535 - spread));
				v[0]   = RAW_W'(lo);
				v[1]   = RAW_W'(lo + spread);
				v[2]   = RAW_W'(lo + int'($urandom_range(spread)));
			end
		endcase
		// shuffle which channel gets the min, the max and the middle
		for (int k = 2; k > 0; k--) begin
			j    = int'($urandom_range(k));
			t    = v[k];
			v[k] = v[j];
			v[j] = t;
		end
		r = v[0];
		g = v[1];
		b = v[2];
	endtask

	initial begin : stimulus
		logic [RAW_W-1:0] r;
		logic [RAW_W-1:0] g;
		logic [RAW_W-1:0] b;
		logic [RAW_W-1:0] phase_thresh [7];
		int               phase_items;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset threshold: flat below 20, normal from 20 up
		send_pixel(16'd0, 16'd0, 16'd0);
		send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_pixel(16'd100, 16'd119, 16'd110);
		send_pixel(16'd100, 16'd120, 16'd110);
		send_pixel(16'd0, 16'hFFFF, 16'h8000);
		send_pixel(16'hFFFF, 16'd0, 16'd1);
		send_pixel(16'd1, 16'hFFFE, 16'hFFFF);
		send_pixel(16'd40000, 16'd40000, 16'd0);
		send_pixel(16'h5555, 16'hAAAA, 16'h0F0F);
		send_pixel(16'hAAAA, 16'h5555, 16'hF0F0);

		// zero threshold: flat never, zero spread gives all zero duties
		write_thresh(16'd0);
		send_pixel(16'd7, 16'd7, 16'd7);
		send_pixel(16'd0, 16'd0, 16'd0);
		send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_pixel(16'd0, 16'd1, 16'd0);
		send_pixel(16'hFFFF, 16'hFFFE, 16'hFFFF);

		// largest threshold: only the full-range spread escapes flat
		write_thresh(16'hFFFF);
		send_pixel(16'd0, 16'hFFFF, 16'd12345);
		send_pixel(16'hFFFF, 16'd1, 16'd0);
		send_pixel(16'd0, 16'hFFFE, 16'd300);

		write_thresh(16'd1);
		send_pixel(16'd9, 16'd9, 16'd9);
		send_pixel(16'd9, 16'd10, 16'd9);

		// random phases, each under its own threshold
		phase_thresh[0] = 16'd0;
		phase_thresh[1] = 16'hFFFF;
		phase_thresh[2] = 16'd1;
		phase_thresh[3] = RAW_W'($urandom_range(65535));
		phase_thresh[4] = RAW_W'($urandom_range(2, 2000));
		phase_thresh[5] = THRESH_RESET;
		phase_thresh[6] = RAW_W'($urandom_range(65535));
		for (int p = 0; p < 7; p++) begin
			write_thresh(phase_thresh[p]);
			calm <= (p == 4);
			phase_items = (phase_thresh[p] == 16'hFFFF) ? 50 : 230;
			for (int i = 0; i < phase_items; i++) begin
				random_pixel(r, g, b);
				send_pixel(r, g, b);
				if (p == 2 && i == 115)
					drain();
			end
		end
		calm <= 1'b0;

		drain();
		repeat (4) @(posedge clk);
		$display("sent %0d requests, checked %0d results (%0d flat)", sent, results,
			flat_results);
		$display("thresholds: reset value, 0, 1, 65535 and random settings");
		if (errors == 0 && pending == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// hard stop well beyond the slowest correct run
	initial begin
		#8000000;
		$display("timeout with %0d results still pending", pending);
		$display("simulation failed");
		$finish;
	end

endmodule

@@ rgb_inverse_minmax_normalizer.f @@
+incdir+hw/rtl
hw/rtl/rimn_pkg.sv
hw/rtl/rimn_front.sv
hw/rtl/rimn_queue.sv
hw/rtl/rimn_back.sv
hw/rtl/rgb_inverse_minmax_normalizer.sv
verif/rimn_checker.sv
verif/tb_top.sv
